// ===== sv/pdri_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdri_pkg
// Shared types, constants, microcode program and sine table for the planar
// dead reckoning integrator.
// ---------------------------------------------------------------------------
package pdri_pkg;

    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_PROD_W        = 16 + SINE_IDX_W;

    localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [7:0]  AGE_MAX      = 8'd255;

    localparam logic [31:0] RST_START_X       = 32'd196608;
    localparam logic [31:0] RST_START_Y       = 32'd655360;
    localparam logic [31:0] RST_START_Z       = 32'd32768;
    localparam logic [15:0] RST_START_HEADING = 16'd0;
    localparam logic [15:0] RST_STEP_TIME     = 16'd655;
    localparam logic [7:0]  RST_TIMEOUT       = 8'd55;

    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_START_X       = 3'd0,
        REG_START_Y       = 3'd1,
        REG_START_Z       = 3'd2,
        REG_START_HEADING = 3'd3,
        REG_STEP_TIME     = 3'd4,
        REG_TIMEOUT       = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        MA_VX,
        MA_VY,
        MA_WR,
        MA_ACC_A,
        MA_ACC_B
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_COS,
        MB_SIN,
        MB_DT
    } t_mul_b;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [1:0] {
        POSE_HOLD,
        POSE_X,
        POSE_Y,
        POSE_H
    } t_pose_op;

    typedef enum logic {
        JMP_NONE,
        JMP_IF_CMD
    } t_jump;

    typedef logic [3:0] t_step;

    localparam t_step STEP_DISPATCH = 4'd0;
    localparam t_step STEP_PREP     = 4'd1;
    localparam t_step STEP_VX_COS   = 4'd2;
    localparam t_step STEP_VY_SIN   = 4'd3;
    localparam t_step STEP_VY_COS   = 4'd4;
    localparam t_step STEP_DX_DT    = 4'd5;
    localparam t_step STEP_VX_SIN   = 4'd6;
    localparam t_step STEP_WR_DT    = 4'd7;
    localparam t_step STEP_DY_DT    = 4'd8;
    localparam t_step STEP_EMIT     = 4'd9;
    localparam t_step STEP_CMD      = 4'd10;

    typedef struct packed {
        t_mul_a   mul_a;
        t_mul_b   mul_b;
        logic     mul_en;
        t_acc_op  a_op;
        t_acc_op  b_op;
        t_pose_op pose_op;
        logic     prep;
        logic     latch_cmd;
        logic     emit;
        logic     last;
        t_jump    jump;
        t_step    target;
    } t_ctrl;

    localparam t_ctrl CTRL_IDLE = '{
        mul_a:     MA_VX,
        mul_b:     MB_COS,
        mul_en:    1'b0,
        a_op:      ACC_HOLD,
        b_op:      ACC_HOLD,
        pose_op:   POSE_HOLD,
        prep:      1'b0,
        latch_cmd: 1'b0,
        emit:      1'b0,
        last:      1'b0,
        jump:      JMP_NONE,
        target:    STEP_DISPATCH
    };

    function automatic t_ctrl microcode(t_step s);
        t_ctrl c;
        c = CTRL_IDLE;
        case (s)
            STEP_DISPATCH: begin
                c.jump   = JMP_IF_CMD;
                c.target = STEP_CMD;
            end
            STEP_PREP: begin
                c.prep = 1'b1;
            end
            STEP_VX_COS: begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_VX;
                c.mul_b  = MB_COS;
            end
            STEP_VY_SIN: begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_VY;
                c.mul_b  = MB_SIN;
                c.a_op   = ACC_LOAD;
            end
            STEP_VY_COS: begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_VY;
                c.mul_b  = MB_COS;
                c.a_op   = ACC_SUB;
            end
            STEP_DX_DT: begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_ACC_A;
                c.mul_b  = MB_DT;
                c.b_op   = ACC_LOAD;
            end
            STEP_VX_SIN: begin
                c.mul_en  = 1'b1;
                c.mul_a   = MA_VX;
                c.mul_b   = MB_SIN;
                c.pose_op = POSE_X;
            end
            STEP_WR_DT: begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_WR;
                c.mul_b  = MB_DT;
                c.b_op   = ACC_ADD;
            end
            STEP_DY_DT: begin
                c.mul_en  = 1'b1;
                c.mul_a   = MA_ACC_B;
                c.mul_b   = MB_DT;
                c.pose_op = POSE_H;
            end
            STEP_EMIT: begin
                c.pose_op = POSE_Y;
                c.emit    = 1'b1;
                c.last    = 1'b1;
            end
            STEP_CMD: begin
                c.latch_cmd = 1'b1;
                c.last      = 1'b1;
            end
            default: begin
                c.last = 1'b1;
            end
        endcase
        return c;
    endfunction

    typedef logic signed [15:0] t_sine_rom [SINE_TABLE_ENTRIES];

    function automatic logic signed [15:0] sine_entry(int unsigned k);
        logic [63:0]        a64;
        logic [1:0]         q;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        mag;
        logic signed [15:0] res;
        a64  = ({32'd0, k} << 32) / SINE_TABLE_ENTRIES;
        q    = a64[31:30];
        r    = {34'd0, a64[29:0]};
        if (q[0]) begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * Q30_HALF_PI) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        mag = ($unsigned(sum) + 64'd32768) >> 16;
        res = q[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
        return res;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom t;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    function automatic logic [SINE_IDX_W-1:0] sine_index(logic [15:0] ang);
        logic [SINE_PROD_W-1:0] p;
        p = SINE_PROD_W'(ang) * SINE_PROD_W'(SINE_TABLE_ENTRIES);
        return p[SINE_PROD_W-1:16];
    endfunction

endpackage

// ===== sv/pdri_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdri channel interfaces
// Valid/ready channels for command/tick words and pose result words.
// ---------------------------------------------------------------------------
interface pdri_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] cmd_vel_x;
    logic signed [15:0] cmd_vel_y;
    logic signed [23:0] cmd_turn_rate;

    modport source (
        output valid, opcode, cmd_vel_x, cmd_vel_y, cmd_turn_rate,
        input  ready
    );
    modport sink (
        input  valid, opcode, cmd_vel_x, cmd_vel_y, cmd_turn_rate,
        output ready
    );
endinterface

interface pdri_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] heading;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [23:0] turn_rate;

    modport source (
        output valid, pos_x, pos_y, pos_z, heading, vel_x, vel_y, turn_rate,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, heading, vel_x, vel_y, turn_rate,
        output ready
    );
endinterface

// ===== sv/pdri_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdri_seq
// Microcode sequencer: step counter, program lookup and conditional jump.
// ---------------------------------------------------------------------------
module pdri_seq
    import pdri_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_is_cmd,
    input  logic  i_stall,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    logic  r_busy;
    logic  n_busy;
    t_step r_step;
    t_step n_step;
    t_ctrl w_word;

    assign w_word = microcode(r_step);
    assign o_ctrl = r_busy ? w_word : CTRL_IDLE;
    assign o_busy = r_busy;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = STEP_DISPATCH;
            end
        end else if (!i_stall) begin
            if (w_word.last) begin
                n_busy = 1'b0;
            end else if (w_word.jump == JMP_IF_CMD && i_is_cmd) begin
                n_step = w_word.target;
            end else begin
                n_step = r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_DISPATCH;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

endmodule

// ===== sv/planar_dead_reckoning_integrator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// planar_dead_reckoning_integrator_core
// Tick word: the pose result is registered at the emit step, which stalls on back-pressure.
// Command word: no result. No new word is accepted until the program ends.
// All products go through the single shared 32x17 multiplier stepped by the microcode.
// Synchronous active-low reset restores start registers, pose, zero velocity
// and a stale command age; the sine table is a constant ROM, no fill pass.
// ---------------------------------------------------------------------------
module planar_dead_reckoning_integrator_core
    import pdri_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    pdri_in_if.sink            i_in,
    pdri_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] r_start_x;
    logic [31:0] r_start_y;
    logic [31:0] r_start_z;
    logic [15:0] r_start_h;
    logic [15:0] r_step_time;
    logic [7:0]  r_timeout;

    logic [31:0]        r_pose_x;
    logic [31:0]        r_pose_y;
    logic [15:0]        r_pose_h;
    logic signed [15:0] r_held_vx;
    logic signed [15:0] r_held_vy;
    logic signed [23:0] r_held_wr;
    logic [7:0]         r_age;

    logic               r_op;
    logic signed [15:0] r_cmd_vx;
    logic signed [15:0] r_cmd_vy;
    logic signed [23:0] r_cmd_wr;

    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    logic signed [48:0] r_prod;
    logic signed [31:0] r_acc_a;
    logic signed [31:0] r_acc_b;

    logic               r_out_valid;
    logic [31:0]        r_out_x;
    logic [31:0]        r_out_y;
    logic [31:0]        r_out_z;
    logic [15:0]        r_out_h;
    logic signed [15:0] r_out_vx;
    logic signed [15:0] r_out_vy;
    logic signed [23:0] r_out_wr;

    logic               w_busy;
    t_ctrl              w_ctrl;
    logic               w_accept;
    logic               w_stall;
    logic               w_adv_emit;
    logic               w_cfg_wr;
    t_reg_idx           w_reg;
    logic signed [31:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [48:0] w_prod;
    logic [31:0]        w_round22;
    logic [15:0]        w_round16;

    function automatic logic [31:0] round_q22(logic signed [48:0] v);
        logic signed [49:0] t;
        t = (50'(v) + (50'sd1 <<< 21)) >>> 22;
        return t[31:0];
    endfunction

    function automatic logic [15:0] round_q16(logic signed [48:0] v);
        logic signed [49:0] t;
        t = (50'(v) + (50'sd1 <<< 15)) >>> 16;
        return t[15:0];
    endfunction

    pdri_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_is_cmd (r_op),
        .i_stall  (w_stall),
        .o_busy   (w_busy),
        .o_ctrl   (w_ctrl)
    );

    assign i_in.ready  = !w_busy;
    assign w_accept    = i_in.valid && !w_busy;
    assign w_stall     = w_ctrl.emit && r_out_valid && !o_out.ready;
    assign w_adv_emit  = w_ctrl.emit && !w_stall;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign w_reg       = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign pready      = 1'b1;
    assign w_round22   = round_q22(r_prod);
    assign w_round16   = round_q16(r_prod);

    always_comb begin
        case (w_reg)
            REG_START_X:       prdata = r_start_x;
            REG_START_Y:       prdata = r_start_y;
            REG_START_Z:       prdata = r_start_z;
            REG_START_HEADING: prdata = {16'd0, r_start_h};
            REG_STEP_TIME:     prdata = {16'd0, r_step_time};
            REG_TIMEOUT:       prdata = {24'd0, r_timeout};
            default:           prdata = 32'd0;
        endcase
    end

    always_comb begin
        case (w_ctrl.mul_a)
            MA_VX:    w_mul_a = 32'(r_held_vx);
            MA_VY:    w_mul_a = 32'(r_held_vy);
            MA_WR:    w_mul_a = 32'(r_held_wr);
            MA_ACC_A: w_mul_a = r_acc_a;
            MA_ACC_B: w_mul_a = r_acc_b;
            default:  w_mul_a = 32'sd0;
        endcase
        case (w_ctrl.mul_b)
            MB_COS:  w_mul_b = 17'(r_cos);
            MB_SIN:  w_mul_b = 17'(r_sin);
            MB_DT:   w_mul_b = $signed({1'b0, r_step_time});
            default: w_mul_b = 17'sd0;
        endcase
        w_prod = w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_in.opcode;
            r_cmd_vx <= i_in.cmd_vel_x;
            r_cmd_vy <= i_in.cmd_vel_y;
            r_cmd_wr <= i_in.cmd_turn_rate;
        end
        if (w_ctrl.prep) begin
            r_sin <= SINE_ROM[sine_index(r_pose_h)];
            r_cos <= SINE_ROM[sine_index(r_pose_h + QUARTER_TURN)];
        end
        if (w_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
        case (w_ctrl.a_op)
            ACC_LOAD: r_acc_a <= r_prod[31:0];
            ACC_ADD:  r_acc_a <= r_acc_a + r_prod[31:0];
            ACC_SUB:  r_acc_a <= r_acc_a - r_prod[31:0];
            default:  r_acc_a <= r_acc_a;
        endcase
        case (w_ctrl.b_op)
            ACC_LOAD: r_acc_b <= r_prod[31:0];
            ACC_ADD:  r_acc_b <= r_acc_b + r_prod[31:0];
            ACC_SUB:  r_acc_b <= r_acc_b - r_prod[31:0];
            default:  r_acc_b <= r_acc_b;
        endcase
        if (w_adv_emit) begin
            r_out_x  <= r_pose_x;
            r_out_y  <= r_pose_y + w_round22;
            r_out_z  <= r_start_z;
            r_out_h  <= r_pose_h;
            r_out_vx <= r_held_vx;
            r_out_vy <= r_held_vy;
            r_out_wr <= r_held_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= RST_START_X;
            r_start_y   <= RST_START_Y;
            r_start_z   <= RST_START_Z;
            r_start_h   <= RST_START_HEADING;
            r_step_time <= RST_STEP_TIME;
            r_timeout   <= RST_TIMEOUT;
            r_pose_x    <= RST_START_X;
            r_pose_y    <= RST_START_Y;
            r_pose_h    <= RST_START_HEADING;
            r_held_vx   <= 16'sd0;
            r_held_vy   <= 16'sd0;
            r_held_wr   <= 24'sd0;
            r_age       <= AGE_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_reg)
                    REG_START_X: begin
                        r_start_x <= pwdata;
                        r_pose_x  <= pwdata;
                    end
                    REG_START_Y: begin
                        r_start_y <= pwdata;
                        r_pose_y  <= pwdata;
                    end
                    REG_START_Z: begin
                        r_start_z <= pwdata;
                    end
                    REG_START_HEADING: begin
                        r_start_h <= pwdata[15:0];
                        r_pose_h  <= pwdata[15:0];
                    end
                    REG_STEP_TIME: begin
                        r_step_time <= pwdata[15:0];
                    end
                    REG_TIMEOUT: begin
                        r_timeout <= pwdata[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_ctrl.latch_cmd) begin
                r_held_vx <= r_cmd_vx;
                r_held_vy <= r_cmd_vy;
                r_held_wr <= r_cmd_wr;
                r_age     <= 8'd0;
            end
            if (w_ctrl.prep) begin
                if (r_age >= r_timeout) begin
                    r_held_vx <= 16'sd0;
                    r_held_vy <= 16'sd0;
                    r_held_wr <= 24'sd0;
                end
                if (r_age != AGE_MAX) begin
                    r_age <= r_age + 8'd1;
                end
            end
            case (w_ctrl.pose_op)
                POSE_X: r_pose_x <= r_pose_x + w_round22;
                POSE_H: r_pose_h <= r_pose_h + w_round16;
                POSE_Y: begin
                    if (w_adv_emit) begin
                        r_pose_y <= r_pose_y + w_round22;
                    end
                end
                default: begin
                end
            endcase
            if (w_adv_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pos_x     = $signed(r_out_x);
    assign o_out.pos_y     = $signed(r_out_y);
    assign o_out.pos_z     = $signed(r_out_z);
    assign o_out.heading   = $signed(r_out_h);
    assign o_out.vel_x     = r_out_vx;
    assign o_out.vel_y     = r_out_vy;
    assign o_out.turn_rate = r_out_wr;

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_busy
    ) else $error("sequencer not busy after accepting a word");

    a_stale_zeroes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.prep && r_age >= r_timeout)
            |=> (r_held_vx == 16'sd0 && r_held_vy == 16'sd0 && r_held_wr == 24'sd0)
    ) else $error("stale command not cleared on tick");

    a_age_saturates: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.prep && r_age == AGE_MAX) |=> (r_age == AGE_MAX)
    ) else $error("command age wrapped");

    a_cmd_clears_age: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.latch_cmd |=> (r_age == 8'd0)
    ) else $error("command did not clear age");

    a_emit_fills_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_adv_emit |=> r_out_valid
    ) else $error("emitted result not held in output register");

endmodule
